@@ rtl/core/keyframe_table_linear_interpolator_core_assert.svh @@
// assertion macros for the keyframe interpolator rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef KEYFRAME_TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_TABLE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kti_pkg.sv @@
// types, constants and codes of the keyframe table interpolator
// no dependencies
package kti_pkg;

    localparam int STORE_WORDS = 4096;
    localparam int ENTRY_WORDS = 18;
    localparam int MAT_ELEMS   = 16;
    localparam int W_BITS      = 16;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int CNT_W       = $clog2(STORE_WORDS + 1);
    localparam int ENTRY_MAX   = STORE_WORDS / ENTRY_WORDS;
    localparam int ENT_W       = $clog2(ENTRY_MAX + 1);
    localparam int WIE_W       = $clog2(ENTRY_WORDS);

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] load_word;
        logic signed [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [4:0]         element_index;
        logic signed [31:0] value;
        logic               last;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] data;
    } t_cmd;

endpackage

@@ rtl/core/kti_front.sv @@
// front end: accepts input words, drops unused kinds, queues commands
// depends on kti_pkg
module kti_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  kti_pkg::t_in_item i_in,
    output logic             o_q_valid,
    output kti_pkg::t_cmd    o_q_cmd,
    input  logic             i_q_pop
);
    import kti_pkg::*;

    localparam int QD = 4;

    t_cmd       r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       acc, keep, push;
    t_cmd       cmd;

    // classify the incoming word
    assign acc  = i_in_valid && !o_in_stall;
    assign keep = (i_in.kind == KIND_CLEAR) || (i_in.kind == KIND_LOAD)
                  || (i_in.kind == KIND_QUERY);
    assign push = acc && keep;
    always_comb begin
        cmd.kind = i_in.kind;
        cmd.data = (i_in.kind == KIND_LOAD) ? i_in.load_word : i_in.query_time;
    end

    assign o_in_stall = (r_cnt == 3'(QD));
    assign o_q_valid  = (r_cnt != 3'd0);
    assign o_q_cmd    = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_q_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_q_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end

endmodule

@@ rtl/core/kti_div.sv @@
// restoring divider for the q0.16 weight, one quotient bit per cycle
// depends on kti_pkg
module kti_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [32:0]         i_num,
    input  logic [32:0]         i_den,
    output logic                o_done,
    output logic [kti_pkg::W_BITS-1:0] o_quot
);
    import kti_pkg::*;

    logic [33:0]       r_rem, rem2;
    logic [32:0]       r_den;
    logic [W_BITS-1:0] r_q;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              ge;

    assign rem2   = {r_rem[32:0], 1'b0};
    assign ge     = rem2 >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == 5'(W_BITS));
    assign o_quot = r_q;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy && !o_done) begin
            r_rem <= ge ? rem2 - {1'b0, r_den} : rem2;
            r_q   <= {r_q[W_BITS-2:0], ge};
        end
    end

endmodule

@@ rtl/core/kti_back.sv @@
// back end: table store, entry search, weight and blend of 17 values
// depends on kti_pkg, kti_div and the assertion macro header
module kti_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  kti_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kti_pkg::t_out_item o_out
);
    import kti_pkg::*;
    `include "keyframe_table_linear_interpolator_core_assert.svh"

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PER  = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_SUM  = 8'b0100_0000,
        S_FAIL = 8'b1000_0000
    } t_state;

    localparam int PW = ADDR_W + ENT_W;

    logic [31:0]        mem [STORE_WORDS];
    t_state             r_st;
    logic [CNT_W-1:0]   r_wcnt;
    logic [WIE_W-1:0]   r_wie;
    logic [ENT_W-1:0]   r_ecnt, r_k;
    logic [ADDR_W-1:0]  r_kaddr, r_pa, r_ha, rd_a, rd_b;
    logic [4:0]         r_j;
    logic signed [31:0] r_rda, r_rdb, r_qt, r_c, r_tprev, t1, cl;
    logic signed [32:0] num, den;
    logic [16:0]        r_w2, w1;
    logic signed [49:0] r_pra, r_prb;
    logic signed [50:0] sum;
    logic               r_ovalid, out_free, we, div_start, div_done;
    logic               emit, last_emit;
    logic [W_BITS-1:0]  quot;
    logic [PW-1:0]      per_prod;
    t_out_item          r_out;

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_q_pop     = (r_st == S_IDLE) && i_q_valid;
    assign we          = o_q_pop && (i_q_cmd.kind == KIND_LOAD)
                         && (r_wcnt < CNT_W'(STORE_WORDS));
    assign per_prod    = PW'(r_ecnt - 1'b1) * PW'(ENTRY_WORDS);
    assign emit        = out_free && ((r_st == S_SUM) || (r_st == S_FAIL));
    assign last_emit   = (r_st == S_SUM) && out_free && (r_j == 5'(MAT_ELEMS));

    // read addresses
    always_comb begin
        rd_a = per_prod[ADDR_W-1:0];
        rd_b = r_ha;
        unique case (r_st)
            S_PER:  rd_a = '0;
            S_SCAN: rd_a = r_kaddr + ADDR_W'(ENTRY_WORDS);
            S_RD:   rd_a = r_pa;
            default: rd_a = per_prod[ADDR_W-1:0];
        endcase
    end

    // table store with two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) mem[r_wcnt[ADDR_W-1:0]] <= i_q_cmd.data;
        r_rda <= mem[rd_a];
        r_rdb <= mem[rd_b];
    end

    // clamp and weight operands
    always_comb begin
        if (r_qt < 0) cl = '0;
        else if (r_qt > r_rda) cl = r_rda;
        else cl = r_qt;
        t1  = (r_k == '0) ? r_rda : r_tprev;
        num = 33'(r_c) - 33'(t1);
        den = 33'(r_rda) - 33'(t1);
        w1  = 17'(1 << W_BITS) - r_w2;
        sum = 51'(r_pra) + 51'(r_prb);
    end

    // stop on the first entry not below the time, or on the last entry
    assign div_start = (r_st == S_SCAN)
                       && (!(r_c > r_rda) || (r_k == r_ecnt - 1'b1));

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start && (den > 0) && (num > 0) && (num < den)),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // sequencer and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_wcnt   <= '0;
            r_wie    <= '0;
            r_ecnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output valid: set on a new word, cleared once taken
            if (emit) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_q_pop) begin
                        unique case (i_q_cmd.kind)
                            KIND_CLEAR: begin
                                r_wcnt <= '0;
                                r_wie  <= '0;
                                r_ecnt <= '0;
                            end
                            KIND_LOAD: begin
                                if (we) begin
                                    r_wcnt <= r_wcnt + 1'b1;
                                    if (r_wie == WIE_W'(ENTRY_WORDS - 1)) begin
                                        r_wie  <= '0;
                                        r_ecnt <= r_ecnt + 1'b1;
                                    end else begin
                                        r_wie <= r_wie + 1'b1;
                                    end
                                end
                            end
                            default: begin
                                r_st <= (r_ecnt <= ENT_W'(1)) ? S_FAIL : S_PER;
                            end
                        endcase
                    end
                end
                S_PER: r_st <= (r_rda == 0) ? S_FAIL : S_SCAN;
                S_SCAN: begin
                    if (div_start) begin
                        if (den <= 0 || num <= 0 || num >= den) r_st <= S_RD;
                        else r_st <= S_DIV;
                    end
                end
                S_DIV: if (div_done) r_st <= S_RD;
                S_RD:  r_st <= S_MUL;
                S_MUL: r_st <= S_SUM;
                S_SUM: begin
                    if (out_free) begin
                        r_st <= (r_j == 5'(MAT_ELEMS)) ? S_IDLE : S_RD;
                    end
                end
                S_FAIL: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: r_qt <= i_q_cmd.data;
            S_PER: begin
                r_c     <= cl;
                r_k     <= '0;
                r_kaddr <= '0;
            end
            S_SCAN: begin
                if (div_start) begin
                    r_pa <= ((r_k == '0) ? r_kaddr : r_kaddr - ADDR_W'(ENTRY_WORDS))
                            + 1'b1;
                    r_ha <= r_kaddr + 1'b1;
                    r_j  <= '0;
                    if (den <= 0 || num <= 0) r_w2 <= '0;
                    else if (num >= den) r_w2 <= 17'(1 << W_BITS);
                end else begin
                    r_k     <= r_k + 1'b1;
                    r_kaddr <= r_kaddr + ADDR_W'(ENTRY_WORDS);
                    r_tprev <= r_rda;
                end
            end
            S_DIV: if (div_done) r_w2 <= {1'b0, quot};
            S_MUL: begin
                r_pra <= $signed({1'b0, w1}) * r_rda;
                r_prb <= $signed({1'b0, r_w2}) * r_rdb;
                r_pa  <= r_pa + 1'b1;
                r_ha  <= r_ha + 1'b1;
            end
            S_SUM: begin
                if (out_free) begin
                    r_out.ok            <= 1'b1;
                    r_out.element_index <= r_j;
                    r_out.value         <= sum[47:16];
                    r_out.last          <= (r_j == 5'(MAT_ELEMS));
                    r_j                 <= r_j + 1'b1;
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    r_out.ok            <= 1'b0;
                    r_out.element_index <= '0;
                    r_out.value         <= '0;
                    r_out.last          <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    `KTI_ASSERT_NOW(a_wie_range, 1'b1, r_wie < WIE_W'(ENTRY_WORDS), "entry word position out of range")
    `KTI_ASSERT_NOW(a_ent_fit, 1'b1, (PW'(r_ecnt) * PW'(ENTRY_WORDS)) <= PW'(r_wcnt), "entry overflow")
    `KTI_ASSERT_NEXT(a_last_idle, last_emit, (r_st == S_IDLE) && r_ovalid && r_out.last, "query not closed")

endmodule

@@ rtl/core/keyframe_table_linear_interpolator_core.sv @@
// keyframe interpolator: clear and load are taken by the back end while it is idle
// a query runs a linear entry scan on one memory port, then the bit-serial divider
// when the weight is fractional, then the read, multiply and sum states for each result;
// a 4-deep queue accepts input meanwhile
// synchronous active-low reset empties the queue and the table counts;
// the store contents stay undefined until loaded
module keyframe_table_linear_interpolator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kti_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kti_pkg::t_out_item o_out
);
    import kti_pkg::*;

    logic q_valid, q_pop;
    t_cmd q_cmd;

    // intake and queue
    kti_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // table and interpolation engine
    kti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ dv/testbench.sv @@
// testbench for the keyframe table interpolator core
// depends on kti_pkg and keyframe_table_linear_interpolator_core
`timescale 1ns / 1ps

module testbench;
    import kti_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    keyframe_table_linear_interpolator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    // unused kind code, dropped by the block
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // directed table row codes
    localparam logic [2:0] ROW_CLEAR = 3'd0;
    localparam logic [2:0] ROW_ENTRY = 3'd1;
    localparam logic [2:0] ROW_QUERY = 3'd2;
    localparam logic [2:0] ROW_WORD  = 3'd3;
    localparam logic [2:0] ROW_SKIP  = 3'd4;

    localparam t_out_item FAIL_ITEM = '{1'b0, 5'd0, 32'sd0, 1'b1};
    localparam t_out_item NO_ITEM   = '0;

    // one directed row: an entry, a query, a single word, a clear or a spare kind
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] arg;
        logic [1:0]  mode;
        logic        fixed;
        t_out_item   want;
    } t_dir_row;

    localparam int N_ROWS = 20;

    t_dir_row dir_rows [N_ROWS] = '{
        '{ROW_QUERY, 32'h0000_0000, 2'd0, 1'b1, FAIL_ITEM},  // empty table
        '{ROW_SKIP,  32'hffff_ffff, 2'd0, 1'b0, NO_ITEM},
        '{ROW_ENTRY, 32'h0000_0000, 2'd2, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h7fff_ffff, 2'd0, 1'b1, FAIL_ITEM},  // one entry
        '{ROW_ENTRY, 32'h0000_0000, 2'd1, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h8000_0000, 2'd0, 1'b1, FAIL_ITEM},  // last time zero
        '{ROW_ENTRY, 32'h0001_0000, 2'd2, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h8000_0000, 2'd0, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h7fff_ffff, 2'd0, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h0000_8000, 2'd0, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h0000_0000, 2'd0, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h0000_0001, 2'd0, 1'b0, NO_ITEM},
        '{ROW_WORD,  32'h0001_2345, 2'd0, 1'b0, NO_ITEM},   // partial entry
        '{ROW_QUERY, 32'h0000_4000, 2'd0, 1'b0, NO_ITEM},
        '{ROW_CLEAR, 32'h0000_0000, 2'd0, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h0001_0000, 2'd0, 1'b1, FAIL_ITEM},  // cleared table
        '{ROW_ENTRY, 32'hfffe_0000, 2'd0, 1'b0, NO_ITEM},   // negative last time
        '{ROW_ENTRY, 32'hffff_0000, 2'd3, 1'b0, NO_ITEM},
        '{ROW_QUERY, 32'h0000_0005, 2'd0, 1'b0, NO_ITEM},
        '{ROW_CLEAR, 32'h0000_0000, 2'd0, 1'b0, NO_ITEM}
    };

    // clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // predictor state
    logic [31:0] kf_words [STORE_WORDS];
    int          kf_word_cnt;
    int          kf_word_pos;
    int          kf_entries;
    t_out_item   frames_due [$];
    int          n_errors;
    longint      cycle_cnt;
    bit          hold_long;
    bit          stim_done;

    function automatic longint kf_word(int e, int off);
        int idx;
        idx = e * ENTRY_WORDS + off;
        if (idx >= STORE_WORDS) return 0;
        return longint'($signed(kf_words[idx]));
    endfunction

    function automatic longint floor_q16(longint x);
        if (x >= 0) return x >>> 16;
        return -((-x + 65535) >>> 16);
    endfunction

    // compute expected results of one accepted word
    task automatic predict_item(t_in_item it);
        longint period, c, t1, t2, num, den, w1, w2, r;
        int hit, prev;
        t_out_item o;
        if (it.kind == KIND_CLEAR) begin
            kf_word_cnt = 0; kf_word_pos = 0; kf_entries = 0;
        end else if (it.kind == KIND_LOAD) begin
            if (kf_word_cnt < STORE_WORDS) begin
                kf_words[kf_word_cnt] = it.load_word;
                kf_word_cnt++;
                kf_word_pos++;
                if (kf_word_pos >= ENTRY_WORDS) begin
                    kf_word_pos = 0;
                    kf_entries++;
                end
            end
        end else if (it.kind == KIND_QUERY) begin
            period = (kf_entries > 0) ? kf_word(kf_entries - 1, 0) : 0;
            if (kf_entries <= 1 || period == 0) begin
                o = '0; o.last = 1'b1;
                frames_due.push_back(o);
            end else begin
                c = longint'(it.query_time);
                if (c < 0) c = 0;
                else if (c > period) c = period;
                hit = kf_entries - 1;
                for (int k = 0; k < kf_entries; k++)
                    if (!(c > kf_word(k, 0))) begin
                        hit = k;
                        break;
                    end
                prev = (hit == 0) ? 0 : hit - 1;
                t1 = kf_word(prev, 0);
                t2 = kf_word(hit, 0);
                den = t2 - t1;
                num = c - t1;
                if (den <= 0 || num <= 0) w2 = 0;
                else if (num >= den) w2 = 65536;
                else w2 = (num << 16) / den;
                w1 = 65536 - w2;
                for (int k = 0; k <= MAT_ELEMS; k++) begin
                    r = floor_q16(w1 * kf_word(prev, k + 1) + w2 * kf_word(hit, k + 1));
                    o.ok = 1'b1;
                    o.element_index = k[4:0];
                    o.value = r[31:0];
                    o.last = (k == MAT_ELEMS);
                    frames_due.push_back(o);
                end
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        n_errors++;
    endtask

    // stimulus list, with typed-in results for some words
    t_in_item  words_todo [$];
    bit        fixed_todo [$];
    t_out_item fixed_due [$];

    function automatic t_in_item mk(logic [1:0] k, logic [31:0] w, logic [31:0] q);
        t_in_item it;
        it.kind = k; it.load_word = w; it.query_time = q;
        return it;
    endfunction

    task automatic add_item(t_in_item it);
        words_todo.push_back(it);
        fixed_todo.push_back(1'b0);
    endtask

    task automatic add_fixed(t_in_item it, t_out_item want);
        words_todo.push_back(it);
        fixed_todo.push_back(1'b1);
        fixed_due.push_back(want);
    endtask

    // append an entry with a given time and random or fixed contents
    task automatic push_entry(logic [31:0] t, int mode);
        logic [31:0] w;
        add_item(mk(KIND_LOAD, t, $urandom));
        for (int k = 0; k < 17; k++) begin
            case (mode)
                0: w = $urandom;
                1: w = 32'h7fffffff;
                2: w = 32'h80000000;
                default: w = $urandom_range(0, 65535 * 4) - 65535 * 2;
            endcase
            add_item(mk(KIND_LOAD, w, $urandom));
        end
    endtask

    task automatic push_query(logic [31:0] q);
        add_item(mk(KIND_QUERY, $urandom, q));
    endtask

    // input driver
    initial begin
        t_in_item it;
        bit fx;
        int gap, ne;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0; i_out_stall = 1'b0;
        kf_word_cnt = 0; kf_word_pos = 0; kf_entries = 0;
        n_errors = 0; stim_done = 0; hold_long = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: walk the table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].op)
                ROW_CLEAR: add_item(mk(KIND_CLEAR, $urandom, $urandom));
                ROW_ENTRY: push_entry(dir_rows[i].arg, int'(dir_rows[i].mode));
                ROW_QUERY: begin
                    if (dir_rows[i].fixed)
                        add_fixed(mk(KIND_QUERY, $urandom, dir_rows[i].arg),
                                  dir_rows[i].want);
                    else
                        push_query(dir_rows[i].arg);
                end
                ROW_WORD: add_item(mk(KIND_LOAD, dir_rows[i].arg, $urandom));
                default: add_item(mk(KIND_SPARE, dir_rows[i].arg, dir_rows[i].arg));
            endcase
        end

        // random: a table of a few entries then queries, some noise
        add_item(mk(KIND_CLEAR, $urandom, $urandom));
        ne = $urandom_range(2, 3);
        gap = 0;
        for (int e = 0; e < ne; e++) begin
            gap += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 'h40000);
            push_entry(32'(gap), $urandom_range(0, 3));
        end
        if ($urandom_range(0, 1) == 0)
            for (int k = $urandom_range(1, 6); k > 0; k--)
                add_item(mk(KIND_LOAD, $urandom, $urandom));
        for (int q = 0; q < 6; q++)
            case ($urandom_range(0, 3))
                0: push_query($urandom);
                1: add_item(mk(KIND_SPARE, $urandom, $urandom));
                default: push_query($urandom_range(0, gap + 2));
            endcase

        while (words_todo.size() > 0) begin
            it = words_todo.pop_front();
            fx = fixed_todo.pop_front();
            if ($urandom_range(0, 3) == 0) begin
                i_in_valid = 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
                repeat (gap) @(negedge i_clk);
            end
            i_in = it;
            i_in_valid = 1'b1;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            if (fx) frames_due.push_back(fixed_due.pop_front());
            else predict_item(it);
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        stim_done = 1;
    end

    // long receiver hold-off so the input queue fills
    initial begin
        hold_long = 0;
        wait (i_rst_n);
        repeat (30) @(negedge i_clk);
        hold_long = 1;
        repeat (800) @(negedge i_clk);
        hold_long = 0;
    end

    // output stall pattern
    always @(negedge i_clk) begin
        if (hold_long) i_out_stall <= 1'b1;
        else if ((cycle_cnt / 500) % 3 == 0) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 3) == 0);
    end

    // output checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frames_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = frames_due.pop_front();
                if (o_out.ok !== want.ok)
                    report_mismatch($sformatf("ok %b want %b", o_out.ok, want.ok));
                if (o_out.element_index !== want.element_index)
                    report_mismatch($sformatf("index %0d want %0d",
                        o_out.element_index, want.element_index));
                if (o_out.value !== want.value)
                    report_mismatch($sformatf("value %h want %h", o_out.value, want.value));
                if (o_out.last !== want.last)
                    report_mismatch($sformatf("last %b want %b", o_out.last, want.last));
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_cnt = 0;
        fork
            forever begin
                @(posedge i_clk);
                cycle_cnt++;
            end
        join_none
        fork
            begin
                wait (stim_done && frames_due.size() == 0);
                repeat (600) @(posedge i_clk);
                if (n_errors == 0 && frames_due.size() == 0) $display("tb: success");
                else $display("tb: failure");
            end
            begin
                wait (cycle_cnt >= 1000000);
                $display("tb: failure");
            end
        join_any
        $finish;
    end

endmodule
